// ===== hdl/aee_pkg.sv =====
// aee_pkg: shared types, constants and lookup tables of the envelope evaluator
// no dependencies; used by every module of the block

package aee_pkg;

    // default table depth
    localparam int MAX_POINTS_DEF = 64;

    // field widths
    localparam int BEAT_W  = 32;
    localparam int VALUE_W = 24;
    localparam int CURVE_W = 16;
    localparam int COUNT_W = 7;

    // position within a segment, Q0.16 with room for 1.0
    localparam int T_W      = 17;
    localparam int DIV_STEPS = 16;

    // commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // register map
    localparam int          PADDR_W        = 3;
    localparam logic [2:0]  REG_POINT_COUNT = 3'd0;

    // curve limits, Q2.14
    localparam logic signed [CURVE_W-1:0] CURVE_MAX = 16'sd16384;
    localparam logic signed [CURVE_W-1:0] CURVE_MIN = -16'sd16384;

    // main sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SRCH,
        ST_CLAMP,
        ST_RD0,
        ST_RD1,
        ST_DIV,
        ST_SHAPE_GO,
        ST_SHAPE,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } aee_state_t;

    // shaper states
    typedef enum logic [2:0] {
        SH_IDLE,
        SH_LOG,
        SH_MUL,
        SH_EXP,
        SH_DONE
    } aee_sh_state_t;

    typedef logic [16:0] tab_t [256];

    // integer square root
    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned x;
        x = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2(1+k/256) in Q0.16 by repeated squaring
    function automatic tab_t build_log_tab();
        tab_t            tab;
        longint unsigned x;
        logic [16:0]     r;
        for (int k = 0; k < 256; k++) begin
            x = (64'd1 << 30) + (64'(k) << 22);
            r = '0;
            for (int i = 1; i <= 16; i++) begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30)) begin
                    x = x >> 1;
                    r = r | (17'd1 << (16 - i));
                end
            end
            tab[k] = r;
        end
        return tab;
    endfunction

    // 2^(k/256) in Q1.16 from products of square roots of two
    function automatic tab_t build_exp_tab();
        tab_t            tab;
        longint unsigned roots [8];
        longint unsigned acc;
        longint unsigned one;
        one = 64'd1 << 30;
        roots[0] = isqrt64(64'd1 << 61);
        for (int j = 1; j < 8; j++) roots[j] = isqrt64(roots[j-1] << 30);
        for (int k = 0; k < 256; k++) begin
            acc = one;
            for (int j = 0; j < 8; j++) begin
                if (((k >> (7 - j)) & 1) != 0) acc = (acc * roots[j] + (one >> 1)) >> 30;
            end
            tab[k] = 17'((acc + (64'd1 << 13)) >> 14);
        end
        return tab;
    endfunction

    localparam tab_t LOG_TAB = build_log_tab();
    localparam tab_t EXP_TAB = build_exp_tab();

    // log2 of a normalized mantissa (top bit set), fraction in Q0.16
    function automatic logic [16:0] log_interp(logic [15:0] n);
        logic [7:0]  k;
        logic [16:0] l0;
        logic [16:0] l1;
        logic [23:0] prod;
        k    = n[14:7];
        l0   = LOG_TAB[k];
        l1   = (k == 8'd255) ? 17'd65536 : LOG_TAB[8'(k + 8'd1)];
        prod = 24'(l1 - l0) * 24'(n[6:0]);
        return 17'(l0 + 17'(prod >> 7));
    endfunction

    // 2^(f/65536) in Q1.16 for a fraction f
    function automatic logic [17:0] exp_interp(logic [15:0] f);
        logic [7:0]  k;
        logic [17:0] e0;
        logic [17:0] e1;
        logic [25:0] prod;
        k    = f[15:8];
        e0   = {1'b0, EXP_TAB[k]};
        e1   = (k == 8'd255) ? 18'd131072 : {1'b0, EXP_TAB[8'(k + 8'd1)]};
        prod = 26'(e1 - e0) * 26'(f[7:0]);
        return 18'(e0 + 18'(prod >> 8));
    endfunction

endpackage

// ===== hdl/aee_if.sv =====
// aee_if: valid/ready channels for input items and result items
// no dependencies

interface aee_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [5:0]         point_index;
    logic [31:0]        point_beat;
    logic signed [23:0] point_value;
    logic signed [15:0] point_curve;
    logic [31:0]        query_beat;

    modport source (output valid, command, point_index, point_beat, point_value,
                    point_curve, query_beat, input ready);
    modport sink   (input valid, command, point_index, point_beat, point_value,
                    point_curve, query_beat, output ready);
endinterface

interface aee_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] result_value;
    logic               table_empty;

    modport source (output valid, result_value, table_empty, input ready);
    modport sink   (input valid, result_value, table_empty, output ready);
endinterface

// ===== hdl/automation_envelope_eval_unit.sv =====
// automation_envelope_eval_unit: breakpoint envelope evaluator, top level
// depends on aee_pkg, aee_if, aee_div, aee_shaper
// a write item is taken in idle and stored at once; an evaluate item on an empty table goes
// straight to the output register, else the sequencer steps through the first and last probes,
// the binary search probe loop at one memory read per cycle, the clamp, the two breakpoint reads,
// the serial divide when the segment needs one, the shaper, the multiply and the add
// one item is in work at a time; the result waits in an output register
// reset clears point_count and control; the breakpoint memories are not cleared

module automation_envelope_eval_unit
    import aee_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    aee_in_if.sink             in_ch,
    aee_out_if.source          out_ch
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // breakpoint memories
    logic [BEAT_W-1:0]  beat_mem  [MAX_POINTS];
    logic [VALUE_W-1:0] value_mem [MAX_POINTS];
    logic [CURVE_W-1:0] curve_mem [MAX_POINTS];

    logic [BEAT_W-1:0]  beat_rd_reg;
    logic [VALUE_W-1:0] value_rd_reg;
    logic [CURVE_W-1:0] curve_rd_reg;
    logic [AW-1:0]      rd_addr;

    aee_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        count_reg;
    logic [CW-1:0]             n_reg;
    logic [CW-1:0]             n_eff;
    logic [BEAT_W-1:0]         q_reg;
    logic [CW-1:0]             lo_reg, hi_reg, mid_reg;
    logic [CW-1:0]             lo_n, hi_n, mid_n, lo_c, mid_init;
    logic [BEAT_W-1:0]         b0_reg;
    logic signed [VALUE_W-1:0] v0_reg, v1_reg;
    logic signed [CURVE_W-1:0] c_reg;
    logic [T_W-1:0]            t_reg;
    logic signed [42:0]        prod_reg;
    logic signed [VALUE_W-1:0] res_reg;
    logic                      empty_reg;

    logic accept;
    logic is_write;
    logic probe_le;
    logic div_start;
    logic div_done;
    logic [15:0] div_quo;
    logic shp_start;
    logic shp_done;
    logic [T_W-1:0] shaped;
    logic signed [VALUE_W:0] vdiff;

    assign accept   = in_ch.valid && in_ch.ready;
    assign is_write = (in_ch.command == CMD_WRITE);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_POINT_COUNT) ? {25'b0, count_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == REG_POINT_COUNT)
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign n_eff = (32'(count_reg) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_reg);

    // breakpoint write and registered read
    always_ff @(posedge clk)
    begin
        if (accept && is_write && 32'(in_ch.point_index) < 32'(MAX_POINTS))
        begin
            beat_mem[AW'(in_ch.point_index)]  <= in_ch.point_beat;
            value_mem[AW'(in_ch.point_index)] <= in_ch.point_value;
            curve_mem[AW'(in_ch.point_index)] <= in_ch.point_curve;
        end
        beat_rd_reg  <= beat_mem[rd_addr];
        value_rd_reg <= value_mem[rd_addr];
        curve_rd_reg <= curve_mem[rd_addr];
    end

    // binary search step
    always_comb
    begin
        probe_le = (beat_rd_reg <= q_reg);
        lo_n     = probe_le ? CW'(mid_reg + 1'b1) : lo_reg;
        hi_n     = probe_le ? hi_reg : mid_reg;
        mid_n    = CW'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
        mid_init = CW'(n_reg >> 1);
        if (lo_reg < CW'(1))                 lo_c = CW'(1);
        else if (lo_reg > CW'(n_reg - 1'b1)) lo_c = CW'(n_reg - 1'b1);
        else                                 lo_c = lo_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_write)
                begin
                    state_next = (n_eff == '0) ? ST_OUT : ST_FIRST;
                end
            end
            ST_FIRST:    state_next = (q_reg <= beat_rd_reg) ? ST_OUT : ST_LAST;
            ST_LAST:     state_next = (q_reg >= beat_rd_reg) ? ST_OUT : ST_SRCH;
            ST_SRCH:     state_next = (lo_n < hi_n) ? ST_SRCH : ST_CLAMP;
            ST_CLAMP:    state_next = ST_RD0;
            ST_RD0:      state_next = ST_RD1;
            ST_RD1:
            begin
                if (beat_rd_reg <= b0_reg)                      state_next = ST_OUT;
                else if (q_reg <= b0_reg || q_reg >= beat_rd_reg) state_next = ST_SHAPE_GO;
                else                                            state_next = ST_DIV;
            end
            ST_DIV:      if (div_done) state_next = ST_SHAPE_GO;
            ST_SHAPE_GO: state_next = ST_SHAPE;
            ST_SHAPE:    if (shp_done) state_next = ST_MUL;
            ST_MUL:      state_next = ST_ADD;
            ST_ADD:      state_next = ST_OUT;
            ST_OUT:      if (out_ch.ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        div_start    = 1'b0;
        shp_start    = 1'b0;
        rd_addr      = '0;
        unique case (state_reg)
            ST_IDLE:     in_ch.ready = 1'b1;
            ST_FIRST:    rd_addr = AW'(n_reg - 1'b1);
            ST_LAST:     rd_addr = AW'(mid_init);
            ST_SRCH:     rd_addr = AW'(mid_n);
            ST_CLAMP:    rd_addr = AW'(lo_c - 1'b1);
            ST_RD0:      rd_addr = AW'(lo_reg);
            ST_RD1:
            begin
                div_start = (beat_rd_reg > b0_reg) && (q_reg > b0_reg)
                            && (q_reg < beat_rd_reg);
            end
            ST_SHAPE_GO: shp_start = 1'b1;
            ST_OUT:      out_ch.valid = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign vdiff = (VALUE_W+1)'(v1_reg) - (VALUE_W+1)'(v0_reg);

    // evaluation datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                q_reg     <= in_ch.query_beat;
                n_reg     <= n_eff;
                res_reg   <= '0;
                empty_reg <= (n_eff == '0);
            end
            ST_FIRST:    res_reg <= value_rd_reg;
            ST_LAST:
            begin
                res_reg <= value_rd_reg;
                lo_reg  <= '0;
                hi_reg  <= n_reg;
                mid_reg <= mid_init;
            end
            ST_SRCH:
            begin
                lo_reg  <= lo_n;
                hi_reg  <= hi_n;
                mid_reg <= mid_n;
            end
            ST_CLAMP:    lo_reg <= lo_c;
            ST_RD0:
            begin
                b0_reg <= beat_rd_reg;
                v0_reg <= value_rd_reg;
                c_reg  <= curve_rd_reg;
            end
            ST_RD1:
            begin
                v1_reg  <= value_rd_reg;
                res_reg <= value_rd_reg;
                t_reg   <= (q_reg <= b0_reg) ? T_W'(0) : T_W'(65536);
            end
            ST_DIV:      if (div_done) t_reg <= {1'b0, div_quo};
            ST_MUL:      prod_reg <= 43'(vdiff) * $signed({26'b0, shaped}) + 43'sd32768;
            ST_ADD:      res_reg <= VALUE_W'((prod_reg >>> 16) + 43'(v0_reg));
            default:     ;
        endcase
    end

    aee_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (q_reg - b0_reg),
        .den   (beat_rd_reg - b0_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    aee_shaper u_shaper (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (shp_start),
        .t_in   (t_reg),
        .curve  (c_reg),
        .done   (shp_done),
        .shaped (shaped)
    );

    assign out_ch.result_value = res_reg;
    assign out_ch.table_empty  = empty_reg;

endmodule

// ===== hdl/aee_div.sv =====
// aee_div: bit-serial restoring divider giving the segment position t
// depends on aee_pkg

module aee_div
    import aee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [15:0] quo
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      den_reg;
    logic [15:0]      quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      rem2;
    logic             fits;

    // one quotient bit per cycle while busy
    always_comb
    begin
        rem2      = {rem_reg, 1'b0};
        fits      = rem2 >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(rem2 - {1'b0, den_reg}) : rem2[31:0];
            quo_next = {quo_reg[14:0], fits};
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/aee_shaper.sv =====
// aee_shaper: curve shaping t^(2^curve) through log2 and exp2 tables
// depends on aee_pkg

module aee_shaper
    import aee_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [T_W-1:0]            t_in,
    input  logic signed [CURVE_W-1:0] curve,
    output logic                      done,
    output logic [T_W-1:0]            shaped
);

    aee_sh_state_t state_reg, state_next;

    logic [T_W-1:0]            t_reg;
    logic signed [CURVE_W-1:0] c_reg;
    logic [20:0]               neg_reg;
    logic [18:0]               e_reg;
    logic [23:0]               ymag_reg;
    logic [T_W-1:0]            s_reg;

    logic                      bypass;
    logic [3:0]                lz;
    logic [15:0]               mant;
    logic [16:0]               lm;
    logic [20:0]               neg;
    logic signed [17:0]        c4;
    logic [17:0]               me;
    logic [18:0]               e;
    logic [39:0]               prod;
    logic [15:0]               f_neg;
    logic [24:0]               sh_amt;
    logic [17:0]               ms;
    logic [17:0]               s_val;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SH_IDLE: if (start) state_next = SH_LOG;
            SH_LOG:  state_next = bypass ? SH_DONE : SH_MUL;
            SH_MUL:  state_next = SH_EXP;
            SH_EXP:  state_next = SH_DONE;
            SH_DONE: state_next = SH_IDLE;
            default: state_next = SH_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        done = (state_reg == SH_DONE);
    end

    // leading zero count and log2 of t
    always_comb
    begin
        bypass = (c_reg == '0) || (t_reg == '0) || t_reg[16];
        lz = 4'd15;
        for (int i = 0; i < 16; i++)
        begin
            if (t_reg[i]) lz = 4'(15 - i);
        end
        mant = t_reg[15:0] << lz;
        lm   = log_interp(mant);
        neg  = {5'(lz + 5'd1), 16'b0} - 21'(lm);
        // exponent 2^curve
        c4 = {c_reg, 2'b00};
        me = exp_interp(c4[15:0]);
        case (c4[17:16])
            2'b01:   e = {me, 1'b0};
            2'b00:   e = {1'b0, me};
            default: e = {2'b00, me[17:1]};
        endcase
    end

    // exp2 of minus ymag
    always_comb
    begin
        prod   = 40'(neg_reg) * 40'(e_reg);
        f_neg  = 16'(-ymag_reg);
        sh_amt = (25'(ymag_reg) + 25'd65535) >> 16;
        ms     = exp_interp(f_neg);
        s_val  = (sh_amt >= 25'd18) ? 18'd0 : (ms >> sh_amt[4:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            SH_IDLE:
            begin
                if (start)
                begin
                    t_reg <= t_in;
                    if (curve > CURVE_MAX)      c_reg <= CURVE_MAX;
                    else if (curve < CURVE_MIN) c_reg <= CURVE_MIN;
                    else                        c_reg <= curve;
                end
            end
            SH_LOG:
            begin
                s_reg   <= t_reg;
                neg_reg <= neg;
                e_reg   <= e;
            end
            SH_MUL:  ymag_reg <= prod[39:16];
            SH_EXP:  s_reg <= (s_val > 18'd65536) ? 17'd65536 : s_val[16:0];
            default: ;
        endcase
    end

    assign shaped = s_reg;

endmodule

// ===== test/aee_checker.sv =====
`timescale 1ns / 1ps
// aee_checker: watches the config port and both channels of the envelope evaluator,
// predicts every evaluate result and compares it; depends on aee_pkg and aee_if

module aee_checker
    import aee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    aee_in_if                  in_ch,
    aee_out_if                 out_ch,
    output int                 fail_count,
    output int                 pending
);

    localparam int DEPTH = 64;

    typedef struct {
        logic signed [23:0] value;
        logic               empty;
    } env_result_t;

    longint unsigned    log2_lut [256];
    longint unsigned    pow2_lut [256];
    logic [31:0]        beat_mem  [DEPTH];
    logic signed [23:0] value_mem [DEPTH];
    logic signed [15:0] curve_mem [DEPTH];
    logic [COUNT_W-1:0] count_reg;
    env_result_t        expected_results [$];

    // floor square root
    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // lookup tables: log2(1+k/256) q0.16 and 2^(k/256) q1.16
    initial
    begin
        longint unsigned one;
        longint unsigned x;
        longint unsigned acc;
        longint unsigned bits;
        longint unsigned root [8];
        one = 64'd1 << 30;
        root[0] = sqrt_floor(64'd1 << 61);
        for (int j = 1; j < 8; j++) root[j] = sqrt_floor(root[j-1] << 30);
        for (int k = 0; k < 256; k++)
        begin
            x = one + (64'(k) << 22);
            bits = 0;
            for (int i = 1; i <= 16; i++)
            begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30))
                begin
                    x = x >> 1;
                    bits = bits | (64'd1 << (16 - i));
                end
            end
            log2_lut[k] = bits;
            acc = one;
            for (int j = 0; j < 8; j++)
                if (((k >> (7 - j)) & 1) != 0) acc = (acc * root[j] + (one >> 1)) >> 30;
            pow2_lut[k] = (acc + (64'd1 << 13)) >> 14;
        end
    end

    // 2^v with v in q.16
    function automatic longint pow2_q16(longint v);
        longint ip;
        longint f;
        longint e0;
        longint e1;
        longint m;
        int     k;
        ip = v >>> 16;
        f  = v & 65535;
        k  = int'((f >> 8) & 255);
        e0 = longint'(pow2_lut[k]);
        e1 = (k < 255) ? longint'(pow2_lut[k+1]) : 131072;
        m  = e0 + (((e1 - e0) * (f & 255)) >> 8);
        if (ip >= 0) return (ip < 8) ? (m << ip) : 0;
        return (-ip < 64) ? (m >> (-ip)) : 0;
    endfunction

    // t^(2^c), t q0.16, c clamped q2.14
    function automatic longint shape_pos(longint t, longint c);
        int     p;
        int     k;
        longint n;
        longint l0;
        longint l1;
        longint lm;
        longint neg;
        longint e;
        longint s;
        if (c == 0 || t == 0 || t >= 65536) return t;
        p = 15;
        while (((t >> p) & 1) == 0) p--;
        n   = t << (15 - p);
        k   = int'((n >> 7) & 255);
        l0  = longint'(log2_lut[k]);
        l1  = (k < 255) ? longint'(log2_lut[k+1]) : 65536;
        lm  = l0 + (((l1 - l0) * (n & 127)) >> 7);
        neg = longint'(16 - p) * 65536 - lm;
        e   = pow2_q16(c * 4);
        s   = pow2_q16(-((neg * e) >> 16));
        return (s > 65536) ? 65536 : s;
    endfunction

    // envelope value at a query beat
    function automatic env_result_t eval_envelope(logic [31:0] q);
        env_result_t r;
        int          n;
        int          lo;
        int          hi;
        int          mid;
        longint      b0;
        longint      b1;
        longint      t;
        longint      c;
        longint      v0;
        longint      v1;
        longint      prod;
        longint      res;
        r.empty = 1'b0;
        n = (count_reg > DEPTH) ? DEPTH : int'(count_reg);
        if (n == 0)
        begin
            r.value = '0;
            r.empty = 1'b1;
            return r;
        end
        if (q <= beat_mem[0])
        begin
            r.value = value_mem[0];
            return r;
        end
        if (q >= beat_mem[n-1])
        begin
            r.value = value_mem[n-1];
            return r;
        end
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (beat_mem[mid] <= q) lo = mid + 1;
            else hi = mid;
        end
        if (lo < 1) lo = 1;
        if (lo > n - 1) lo = n - 1;
        b0 = longint'(beat_mem[lo-1]);
        b1 = longint'(beat_mem[lo]);
        if (b1 <= b0)
        begin
            r.value = value_mem[lo];
            return r;
        end
        if (longint'(q) <= b0) t = 0;
        else if (longint'(q) >= b1) t = 65536;
        else t = ((longint'(q) - b0) << 16) / (b1 - b0);
        c = longint'(curve_mem[lo-1]);
        if (c > 16384) c = 16384;
        if (c < -16384) c = -16384;
        v0 = longint'(value_mem[lo-1]);
        v1 = longint'(value_mem[lo]);
        prod = (v1 - v0) * shape_pos(t, c) + 32768;
        if (prod >= 0) res = prod / 65536;
        else res = -((-prod + 65535) / 65536);
        r.value = 24'(res + v0);
        return r;
    endfunction

    // track config, predict on input items, compare result items
    always @(posedge clk or negedge rst_n)
    begin
        env_result_t exp_r;
        if (!rst_n)
        begin
            count_reg = '0;
            fail_count = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_POINT_COUNT)
                count_reg = pwdata[COUNT_W-1:0];
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.command == CMD_WRITE)
                begin
                    beat_mem[in_ch.point_index]  = in_ch.point_beat;
                    value_mem[in_ch.point_index] = in_ch.point_value;
                    curve_mem[in_ch.point_index] = in_ch.point_curve;
                end
                else
                    expected_results.push_back(eval_envelope(in_ch.query_beat));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result item value %0d empty %0b", $realtime,
                             out_ch.result_value, out_ch.table_empty);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.value !== out_ch.result_value)
                    begin
                        $display("%0t: result_value expected %0d actual %0d", $realtime,
                                 exp_r.value, out_ch.result_value);
                        fail_count++;
                    end
                    if (exp_r.empty !== out_ch.table_empty)
                    begin
                        $display("%0t: table_empty expected %0b actual %0b", $realtime,
                                 exp_r.empty, out_ch.table_empty);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== test/automation_envelope_eval_unit_tb.sv =====
`timescale 1ns / 1ps
// automation_envelope_eval_unit_tb: stimulus and verdict for the envelope evaluator
// depends on aee_pkg, aee_if, the block and aee_checker

module automation_envelope_eval_unit_tb;
    import aee_pkg::*;

    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE_TICKS = 64;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 gap_pct;
    int                 stall_pct;
    int                 quiet_ticks;
    int                 live_count;
    logic [31:0]        beat_copy [64];

    aee_in_if  in_ch ();
    aee_out_if out_ch ();

    automation_envelope_eval_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    aee_checker u_checker (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .in_ch(in_ch), .out_ch(out_ch),
        .fail_count(fail_count), .pending(pending)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // receiver stalls
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no accepted item and no config access
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable))
            quiet_ticks <= 0;
        else if (quiet_ticks >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_ticks <= quiet_ticks + 1;
    end

    // one register write, setup then access
    task automatic write_count(logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_POINT_COUNT;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        live_count = (val[6:0] > 64) ? 64 : int'(val[6:0]);
    endtask

    // stop sending and let the block drain before touching config
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic send_item(logic cmd, logic [5:0] idx, logic [31:0] beat,
                             logic [23:0] val, logic [15:0] crv, logic [31:0] q);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.point_index <= idx;
        in_ch.point_beat  <= beat;
        in_ch.point_value <= val;
        in_ch.point_curve <= crv;
        in_ch.query_beat  <= q;
        do @(posedge clk); while (!in_ch.ready);
        if (cmd == CMD_WRITE) beat_copy[idx] = beat;
    endtask

    task automatic send_point(int idx, logic [31:0] beat, logic [23:0] val, logic [15:0] crv);
        send_item(CMD_WRITE, 6'(idx), beat, val, crv, $urandom);
    endtask

    task automatic send_query(logic [31:0] q);
        send_item(CMD_EVAL, 6'($urandom), $urandom, 24'($urandom), 16'($urandom), q);
    endtask

    // sorted table with random content, with ties or disorder on request
    task automatic fill_table(int flavor);
        logic [31:0] beats [$];
        logic [15:0] crv;
        for (int i = 0; i < 64; i++) beats.push_back($urandom);
        beats.sort();
        if (flavor == 1)
            for (int i = 0; i < 8; i++)
            begin
                int j;
                j = $urandom_range(62);
                beats[j+1] = beats[j];
            end
        if (flavor == 2)
            for (int i = 0; i < 4; i++) beats[$urandom_range(63)] = $urandom;
        for (int i = 0; i < 64; i++)
        begin
            crv = ($urandom_range(9) == 0) ? 16'($urandom)
                                           : 16'($signed($urandom_range(32768)) - 16384);
            send_point(i, beats[i], 24'($urandom), crv);
        end
    endtask

    // query biased toward segment interiors
    function automatic logic [31:0] pick_query();
        int          i;
        longint      span;
        logic [31:0] b0;
        logic [31:0] b1;
        if (live_count < 2 || $urandom_range(9) == 0) return $urandom;
        i = $urandom_range(live_count - 2);
        b0 = beat_copy[i];
        b1 = beat_copy[i+1];
        if ($urandom_range(9) == 0) return b0;
        if (b1 <= b0) return b0;
        span = longint'(b1) - longint'(b0) + 1;
        return b0 + 32'(longint'({$urandom, $urandom}) % span);
    endfunction

    initial
    begin
        int counts [9];
        counts = '{1, 2, 64, 3, 127, 64, 0, 2, 64};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_WRITE;
        in_ch.point_index = '0;
        in_ch.point_beat = '0;
        in_ch.point_value = '0;
        in_ch.point_curve = '0;
        in_ch.query_beat = '0;
        out_ch.ready = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        quiet_ticks = 0;
        live_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, then extremes on a known table
        send_query(32'h0);
        send_query(32'hFFFF_FFFF);
        send_point(0, 32'h0000_0000, 24'h7F_FFFF, 16'sd16384);
        send_point(1, 32'h0001_0000, 24'h80_0000, -16'sd16384);
        send_point(2, 32'h0002_0000, 24'h00_0000, 16'sd32767);
        send_point(3, 32'h0002_0000, 24'h12_3456, -16'sd32768);
        send_point(4, 32'h0003_0000, 24'h7F_FFFF, 16'sd0);
        send_point(5, 32'hFFFF_FFFF, 24'h80_0000, 16'sd100);
        for (int i = 6; i < 64; i++) send_point(i, 32'hFFFF_FFFF, 24'h00_0001, 16'sd0);
        drain();
        write_count(6);
        send_query(32'h0);
        send_query(32'h0000_8000);
        send_query(32'h0000_0001);
        send_query(32'h0001_FFFF);
        send_query(32'h0001_8000);
        send_query(32'h0002_0000);
        send_query(32'h0002_4000);
        send_query(32'h8000_0000);
        send_query(32'hFFFF_FFFF);
        drain();
        write_count(127);
        send_query(32'h0002_8000);
        send_query(32'hFFFF_FFFE);

        // random phases across idle modes and counts
        for (int ph = 0; ph < 9; ph++)
        begin
            drain();
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 71; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 71; end
                default: begin gap_pct = 28; stall_pct = 28; end
            endcase
            write_count(ph == 3 ? $urandom_range(3, 63) : counts[ph]);
            fill_table(ph % 3);
            for (int i = 0; i < 22; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_point($urandom_range(63), $urandom, 24'($urandom), 16'($urandom));
                else
                    send_query(pick_query());
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== automation_envelope_eval_unit.f =====
hdl/aee_pkg.sv
hdl/aee_if.sv
hdl/aee_div.sv
hdl/aee_shaper.sv
hdl/automation_envelope_eval_unit.sv
test/aee_checker.sv
test/automation_envelope_eval_unit_tb.sv
